// ===== rtl/core/uft_pkg.sv =====
// Shared types, codes and byte-class helpers for the UTF-8 field tokenizer.
// No dependencies; imported by uft_out_if and every module of the block.
`timescale 1ns / 1ps

package uft_pkg;

	// line status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_COMMENT = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_BADUTF  = 3'd3,
		ST_TOOLONG = 3'd4
	} status_t;

	// result kinds
	localparam logic KIND_FIELD = 1'b0;
	localparam logic KIND_LINE  = 1'b1;

	typedef enum logic [3:0] {
		PH_LEAD  = 4'b0001,
		PH_GAP   = 4'b0010,
		PH_FIELD = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	// allowed range of the next continuation byte
	typedef enum logic [1:0] {
		RNG_PLAIN = 2'd0,
		RNG_RAISE = 2'd1,
		RNG_CUT   = 2'd2
	} range_t;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] TAIL_LO   = 8'h80;
	localparam logic [7:0] TAIL_HI   = 8'hBF;
	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD3_CUT = 8'hED;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;
	localparam logic [7:0] RAISE3_LO = 8'hA0;
	localparam logic [7:0] RAISE4_LO = 8'h90;
	localparam logic [7:0] CUT3_HI   = 8'h9F;
	localparam logic [7:0] CUT4_HI   = 8'h8F;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic ok;
		logic [1:0] tails;
		range_t rng;
	} lead_t;

	// one queue entry: optional field record, optional line summary
	typedef struct packed {
		logic fld_v;
		logic [3:0] idx;
		logic [15:0] len;
		logic sum_v;
		logic [3:0] cnt;
		status_t st;
	} res_info_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic lead_t lead_decode(input logic [7:0] b);
		lead_t r;
		r.ok = 1'b1;
		r.tails = 2'd0;
		r.rng = RNG_PLAIN;
		if (b < TAIL_LO) begin
			r.tails = 2'd0;
		end else if (b < LEAD2_LO) begin
			r.ok = 1'b0;
		end else if (b <= LEAD2_HI) begin
			r.tails = 2'd1;
		end else if (b <= LEAD3_HI) begin
			r.tails = 2'd2;
			if (b == LEAD3_LO) r.rng = RNG_RAISE;
			else if (b == LEAD3_CUT) r.rng = RNG_CUT;
		end else if (b <= LEAD4_HI) begin
			r.tails = 2'd3;
			if (b == LEAD4_LO) r.rng = RNG_RAISE;
			else if (b == LEAD4_HI) r.rng = RNG_CUT;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic logic tail_ok(input logic [7:0] b, input logic [1:0] tails,
			input range_t rng);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = TAIL_LO;
		hi = TAIL_HI;
		if (rng == RNG_RAISE) lo = (tails == 2'd2) ? RAISE3_LO : RAISE4_LO;
		else if (rng == RNG_CUT) hi = (tails == 2'd2) ? CUT3_HI : CUT4_HI;
		return (b >= lo) && (b <= hi);
	endfunction

endpackage

// ===== rtl/core/uft_if.sv =====
// Valid/ready channel interfaces for the tokenizer byte input and result output.
// Depends on uft_pkg for the status type.
`timescale 1ns / 1ps

interface uft_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic end_of_line;
	logic zero_length_line;

	modport source (output valid, data_byte, end_of_line, zero_length_line, input ready);
	modport sink (input valid, data_byte, end_of_line, zero_length_line, output ready);
endinterface

interface uft_out_if import uft_pkg::*; #(parameter int OFFSET_BITS = 17);
	logic valid;
	logic ready;
	logic result_kind;
	logic [3:0] field_index;
	logic [OFFSET_BITS-1:0] field_start;
	logic [15:0] field_length;
	logic [3:0] field_count;
	status_t line_status;
	logic last_result;

	modport source (output valid, result_kind, field_index, field_start, field_length,
		field_count, line_status, last_result, input ready);
	modport sink (input valid, result_kind, field_index, field_start, field_length,
		field_count, line_status, last_result, output ready);
endinterface

// ===== rtl/core/uft_front.sv =====
// Front end: holds the line parse state and classifies each byte combinationally.
// Depends on uft_pkg; feeds uft_queue with the results of each byte.
`timescale 1ns / 1ps

module uft_front import uft_pkg::*; #(
	parameter int MAX_FIELD_BYTES = 65535,
	parameter int OFFSET_BITS = 17
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [3:0] cfg_wdata,
	input logic accept,
	input logic [7:0] data_byte,
	input logic end_of_line,
	input logic zero_length_line,
	output res_info_t info,
	output logic [OFFSET_BITS-1:0] start_out
);

	localparam logic [15:0] MAXB = 16'(MAX_FIELD_BYTES);
	localparam logic [OFFSET_BITS-1:0] OMAX = {OFFSET_BITS{1'b1}};

	logic [3:0] max_fields_q;
	phase_t ph_q, ph_n;
	logic [1:0] te_q, te_n;
	range_t rng_q, rng_n;
	logic [15:0] flen_q, flen_n;
	logic [OFFSET_BITS-1:0] fstart_q, fstart_n;
	logic [OFFSET_BITS-1:0] bpos_q, bpos_n;
	logic [3:0] ff_q, ff_n;
	status_t err_q, err_n;

	always_comb begin
		lead_t ld;
		logic fin_req;
		logic nul;
		logic [15:0] lenbase;
		ph_n = ph_q;
		te_n = te_q;
		rng_n = rng_q;
		flen_n = flen_q;
		fstart_n = fstart_q;
		bpos_n = bpos_q;
		ff_n = ff_q;
		err_n = err_q;
		info = '0;
		start_out = '0;
		ld = lead_decode(data_byte);
		fin_req = 1'b0;
		nul = (data_byte == CH_NUL);
		lenbase = (ph_q == PH_FIELD) ? flen_q : 16'd0;

		if (zero_length_line) begin
			ph_n = PH_LEAD;
			te_n = 2'd0;
			rng_n = RNG_PLAIN;
			flen_n = '0;
			fstart_n = '0;
			bpos_n = '0;
			ff_n = '0;
			err_n = ST_OK;
			info.sum_v = 1'b1;
			info.st = ST_EMPTY;
		end else begin
			if (bpos_q != OMAX) bpos_n = bpos_q + 1'b1;

			if (ph_q == PH_FIELD && te_q != 2'd0) begin
				if (tail_ok(data_byte, te_q, rng_q)) begin
					te_n = te_q - 2'd1;
					rng_n = RNG_PLAIN;
					if (flen_q < MAXB) flen_n = flen_q + 16'd1;
				end else begin
					err_n = ST_BADUTF;
					ph_n = PH_DONE;
				end
			end else if (ph_q != PH_DONE) begin
				if (nul || is_space(data_byte)) begin
					case (ph_q)
						PH_LEAD: begin
							if (nul) begin
								err_n = ST_COMMENT;
								ph_n = PH_DONE;
							end
						end
						PH_GAP: begin
							if (nul) begin
								err_n = ST_OK;
								ph_n = PH_DONE;
							end
						end
						default: fin_req = 1'b1;
					endcase
				end else if (ph_q == PH_LEAD && data_byte == CH_HASH) begin
					err_n = ST_COMMENT;
					ph_n = PH_DONE;
				end else if (ph_q == PH_LEAD && max_fields_q == 4'd0) begin
					err_n = ST_OK;
					ph_n = PH_DONE;
				end else begin
					if (ph_q != PH_FIELD) begin
						fstart_n = bpos_q;
						ph_n = PH_FIELD;
					end
					rng_n = ld.rng;
					if (ld.ok) begin
						te_n = ld.tails;
						flen_n = (lenbase < MAXB) ? lenbase + 16'd1 : lenbase;
					end else begin
						flen_n = lenbase;
						err_n = ST_BADUTF;
						ph_n = PH_DONE;
					end
				end
			end

			// a sequence cut off by the line end
			if (end_of_line && ph_n == PH_FIELD && te_n != 2'd0) begin
				err_n = ST_BADUTF;
				ph_n = PH_DONE;
			end

			if (fin_req || (end_of_line && ph_n == PH_FIELD)) begin
				if (flen_n >= MAXB) begin
					err_n = ST_TOOLONG;
					ph_n = PH_DONE;
				end else begin
					info.fld_v = 1'b1;
					info.idx = ff_n;
					info.len = flen_n;
					start_out = fstart_n;
					ff_n = ff_n + 4'd1;
					flen_n = '0;
					if (ff_n >= max_fields_q) begin
						err_n = ST_OK;
						ph_n = PH_DONE;
					end else begin
						ph_n = PH_GAP;
					end
				end
			end

			if (fin_req && nul && ph_n != PH_DONE) begin
				err_n = ST_OK;
				ph_n = PH_DONE;
			end

			if (end_of_line) begin
				info.sum_v = 1'b1;
				info.cnt = ff_n;
				case (ph_n)
					PH_LEAD: info.st = ST_COMMENT;
					PH_GAP: info.st = ST_OK;
					default: info.st = err_n;
				endcase
				ph_n = PH_LEAD;
				te_n = 2'd0;
				rng_n = RNG_PLAIN;
				flen_n = '0;
				fstart_n = '0;
				bpos_n = '0;
				ff_n = '0;
				err_n = ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fields_q <= 4'd3;
			ph_q <= PH_LEAD;
			te_q <= 2'd0;
			rng_q <= RNG_PLAIN;
			flen_q <= '0;
			fstart_q <= '0;
			bpos_q <= '0;
			ff_q <= '0;
			err_q <= ST_OK;
		end else begin
			if (cfg_we) max_fields_q <= cfg_wdata;
			if (accept) begin
				ph_q <= ph_n;
				te_q <= te_n;
				rng_q <= rng_n;
				flen_q <= flen_n;
				fstart_q <= fstart_n;
				bpos_q <= bpos_n;
				ff_q <= ff_n;
				err_q <= err_n;
			end
		end
	end

endmodule

// ===== rtl/core/uft_queue.sv =====
// Short FIFO between front and back end; one entry per byte that gives results.
// Depends on uft_pkg for the depth constant.
`timescale 1ns / 1ps

module uft_queue import uft_pkg::*; #(
	parameter int WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] push_data,
	input logic pop,
	output logic full,
	output logic empty,
	output logic [WIDTH-1:0] head_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/uft_back.sv =====
// Back end: splits each queue entry into field record and line summary results
// and holds them in the output register. Depends on uft_pkg.
`timescale 1ns / 1ps

module uft_back import uft_pkg::*; #(
	parameter int OFFSET_BITS = 17
) (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input res_info_t head,
	input logic [OFFSET_BITS-1:0] head_start,
	output logic pop,
	input logic out_ready,
	output logic out_valid,
	output logic result_kind,
	output logic [3:0] field_index,
	output logic [OFFSET_BITS-1:0] field_start,
	output logic [15:0] field_length,
	output logic [3:0] field_count,
	output status_t line_status,
	output logic last_result
);

	logic ov_q;
	logic second_q;
	logic load;
	logic take;
	logic emit_sum;

	logic kind_q;
	logic [3:0] idx_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic [15:0] len_q;
	logic [3:0] cnt_q;
	status_t st_q;
	logic last_q;

	assign load = !ov_q || out_ready;
	assign take = load && !empty;
	// summary goes out alone, or after the field record of the same entry
	assign emit_sum = !head.fld_v || second_q;
	assign pop = take && (emit_sum || !head.sum_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			ov_q <= !empty;
			if (take) second_q <= !pop;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (emit_sum) begin
				kind_q <= KIND_LINE;
				idx_q <= '0;
				start_q <= '0;
				len_q <= '0;
				cnt_q <= head.cnt;
				st_q <= head.st;
				last_q <= 1'b1;
			end else begin
				kind_q <= KIND_FIELD;
				idx_q <= head.idx;
				start_q <= head_start;
				len_q <= head.len;
				cnt_q <= '0;
				st_q <= ST_OK;
				last_q <= !head.sum_v;
			end
		end
	end

	assign out_valid = ov_q;
	assign result_kind = kind_q;
	assign field_index = idx_q;
	assign field_start = start_q;
	assign field_length = len_q;
	assign field_count = cnt_q;
	assign line_status = st_q;
	assign last_result = last_q;

endmodule

// ===== rtl/core/utf8_field_tokenizer_unit.sv =====
// UTF-8 field tokenizer, top level: front end, result queue, back end.
// Throughput one byte per cycle; a byte that gives two results needs two output transfers,
// absorbed by the four-entry result queue. A result is written to the queue with its byte
// and then registered in the back end output. Byte input stalls only when the queue is full.
// Asynchronous active-low reset returns line state to leading whitespace and
// max_fields to 3.
`timescale 1ns / 1ps

module utf8_field_tokenizer_unit import uft_pkg::*; #(
	parameter int MAX_FIELD_BYTES = 65535,
	parameter int OFFSET_BITS = 17
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [3:0] cfg_wdata,
	uft_in_if.sink in_ch,
	uft_out_if.source out_ch
);

	localparam int QW = $bits(res_info_t) + OFFSET_BITS;

	res_info_t info;
	res_info_t head;
	logic [OFFSET_BITS-1:0] start_out;
	logic [OFFSET_BITS-1:0] head_start;
	logic [QW-1:0] head_data;
	logic accept;
	logic push;
	logic pop;
	logic full;
	logic empty;

	assign in_ch.ready = !full;
	assign accept = in_ch.valid && !full;
	assign push = accept && (info.fld_v || info.sum_v);
	assign head = head_data[QW-1 -: $bits(res_info_t)];
	assign head_start = head_data[OFFSET_BITS-1:0];

	uft_front #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES),
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.accept(accept),
		.data_byte(in_ch.data_byte),
		.end_of_line(in_ch.end_of_line),
		.zero_length_line(in_ch.zero_length_line),
		.info(info),
		.start_out(start_out)
	);

	uft_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({info, start_out}),
		.pop(pop),
		.full(full),
		.empty(empty),
		.head_data(head_data)
	);

	uft_back #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.head_start(head_start),
		.pop(pop),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.result_kind(out_ch.result_kind),
		.field_index(out_ch.field_index),
		.field_start(out_ch.field_start),
		.field_length(out_ch.field_length),
		.field_count(out_ch.field_count),
		.line_status(out_ch.line_status),
		.last_result(out_ch.last_result)
	);

endmodule

// ===== bench/utf8_field_tokenizer_unit_test.sv =====
// Self-checking bench for utf8_field_tokenizer_unit: byte stream in, field/line results out.
// Depends on uft_pkg and the uft_in_if / uft_out_if channel interfaces of the RTL.
`timescale 1ns / 1ps

typedef struct packed {
	logic kind;
	logic [3:0] index;
	logic [16:0] start;
	logic [15:0] length;
	logic [3:0] count;
	uft_pkg::status_t status;
	logic last;
} token_t;

// Tracks line state per accepted byte and holds the results still owed by the block.
class token_tracker #(int unsigned LEN_CAP = 65535);
	logic [3:0] max_fields;
	uft_pkg::phase_t scan;
	logic [1:0] tails;
	uft_pkg::range_t rng;
	int unsigned cur_len;
	logic [16:0] cur_start;
	logic [16:0] pos;
	logic [3:0] found;
	uft_pkg::status_t err;
	token_t expected_tokens[$];
	token_t step_out[$];
	int mismatches;

	function new();
		max_fields = 4'd3;
		mismatches = 0;
		restart_line();
	endfunction

	function void restart_line();
		scan = uft_pkg::PH_LEAD;
		tails = 2'd0;
		rng = uft_pkg::RNG_PLAIN;
		cur_len = 0;
		cur_start = '0;
		pos = '0;
		found = 4'd0;
		err = uft_pkg::ST_OK;
	endfunction

	function void emit(logic kind, logic [3:0] idx, logic [16:0] st, logic [15:0] len,
			logic [3:0] cnt, uft_pkg::status_t s);
		token_t t;
		t.kind = kind;
		t.index = idx;
		t.start = st;
		t.length = len;
		t.count = cnt;
		t.status = s;
		t.last = 1'b0;
		step_out.push_back(t);
	endfunction

	function void halt(uft_pkg::status_t code);
		err = code;
		scan = uft_pkg::PH_DONE;
	endfunction

	function bit blank(logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function void count_byte();
		if (cur_len < LEN_CAP) cur_len++;
	endfunction

	// too-long fields are never emitted
	function void close_field();
		if (cur_len >= LEN_CAP) begin
			halt(uft_pkg::ST_TOOLONG);
			return;
		end
		emit(uft_pkg::KIND_FIELD, found, cur_start, 16'(cur_len), 4'd0, uft_pkg::ST_OK);
		found++;
		cur_len = 0;
		if (found >= max_fields) halt(uft_pkg::ST_OK);
		else scan = uft_pkg::PH_GAP;
	endfunction

	function bit lead_ok(logic [7:0] b);
		rng = uft_pkg::RNG_PLAIN;
		if (b < uft_pkg::TAIL_LO) begin
			tails = 2'd0;
		end else if (b < uft_pkg::LEAD2_LO) begin
			return 1'b0;
		end else if (b <= uft_pkg::LEAD2_HI) begin
			tails = 2'd1;
		end else if (b <= uft_pkg::LEAD3_HI) begin
			tails = 2'd2;
			if (b == uft_pkg::LEAD3_LO) rng = uft_pkg::RNG_RAISE;
			else if (b == uft_pkg::LEAD3_CUT) rng = uft_pkg::RNG_CUT;
		end else if (b <= uft_pkg::LEAD4_HI) begin
			tails = 2'd3;
			if (b == uft_pkg::LEAD4_LO) rng = uft_pkg::RNG_RAISE;
			else if (b == uft_pkg::LEAD4_HI) rng = uft_pkg::RNG_CUT;
		end else begin
			return 1'b0;
		end
		count_byte();
		return 1'b1;
	endfunction

	// first tail after E0/F0 is raised, after ED/F4 is cut
	function bit tail_fits(logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = uft_pkg::TAIL_LO;
		hi = uft_pkg::TAIL_HI;
		if (rng == uft_pkg::RNG_RAISE) begin
			lo = (tails == 2'd2) ? uft_pkg::RAISE3_LO : uft_pkg::RAISE4_LO;
		end else if (rng == uft_pkg::RNG_CUT) begin
			hi = (tails == 2'd2) ? uft_pkg::CUT3_HI : uft_pkg::CUT4_HI;
		end
		if (b < lo || b > hi) return 1'b0;
		tails--;
		rng = uft_pkg::RNG_PLAIN;
		count_byte();
		return 1'b1;
	endfunction

	function void open_field(logic [7:0] b, logic [16:0] p);
		cur_start = p;
		cur_len = 0;
		scan = uft_pkg::PH_FIELD;
		if (!lead_ok(b)) halt(uft_pkg::ST_BADUTF);
	endfunction

	function void take_byte(logic [7:0] b, logic eol, logic zero);
		logic [16:0] p;
		uft_pkg::status_t s;
		step_out.delete();
		p = pos;
		if (zero) begin
			restart_line();
			emit(uft_pkg::KIND_LINE, 4'd0, 17'd0, 16'd0, 4'd0, uft_pkg::ST_EMPTY);
		end else begin
			if (pos != '1) pos++;
			if (scan == uft_pkg::PH_FIELD && tails != 2'd0) begin
				if (!tail_fits(b)) halt(uft_pkg::ST_BADUTF);
			end else if (scan != uft_pkg::PH_DONE) begin
				if (b == uft_pkg::CH_NUL || blank(b)) begin
					if (scan == uft_pkg::PH_LEAD) begin
						if (b == uft_pkg::CH_NUL) halt(uft_pkg::ST_COMMENT);
					end else if (scan == uft_pkg::PH_GAP) begin
						if (b == uft_pkg::CH_NUL) halt(uft_pkg::ST_OK);
					end else begin
						close_field();
						if (b == uft_pkg::CH_NUL && scan != uft_pkg::PH_DONE)
							halt(uft_pkg::ST_OK);
					end
				end else if (scan == uft_pkg::PH_LEAD) begin
					if (b == uft_pkg::CH_HASH) halt(uft_pkg::ST_COMMENT);
					else if (max_fields == 4'd0) halt(uft_pkg::ST_OK);
					else open_field(b, p);
				end else if (scan == uft_pkg::PH_GAP) begin
					open_field(b, p);
				end else if (!lead_ok(b)) begin
					halt(uft_pkg::ST_BADUTF);
				end
			end
			if (eol) begin
				if (scan == uft_pkg::PH_FIELD) begin
					if (tails != 2'd0) halt(uft_pkg::ST_BADUTF);
					else close_field();
				end
				if (scan == uft_pkg::PH_LEAD) s = uft_pkg::ST_COMMENT;
				else if (scan == uft_pkg::PH_GAP) s = uft_pkg::ST_OK;
				else s = err;
				emit(uft_pkg::KIND_LINE, 4'd0, 17'd0, 16'd0, found, s);
				restart_line();
			end
		end
		if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
		foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
	endfunction

	function int pending();
		return expected_tokens.size();
	endfunction

	function void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function void match_token(token_t got);
		token_t want;
		if (expected_tokens.size() == 0) begin
			$error("result_kind %0d arrived with nothing expected", got.kind);
			mismatches++;
			return;
		end
		want = expected_tokens.pop_front();
		check_field("result_kind", want.kind, got.kind);
		check_field("field_index", want.index, got.index);
		check_field("field_start", want.start, got.start);
		check_field("field_length", want.length, got.length);
		check_field("field_count", want.count, got.count);
		check_field("line_status", want.status, got.status);
		check_field("last_result", want.last, got.last);
	endfunction
endclass

module utf8_field_tokenizer_unit_test;
	import uft_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [3:0] cfg_wdata;

	uft_in_if in_ch();
	uft_out_if #(.OFFSET_BITS(17)) out_ch();

	utf8_field_tokenizer_unit #(
		.MAX_FIELD_BYTES(65535),
		.OFFSET_BITS(17)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	token_tracker tracker;
	logic [7:0] line_bytes[$];
	int burst_left = 0;
	int sent_items = 0;
	int unsigned rx_tick = 0;
	logic [7:0] rx_mask = 8'hFF;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("FAIL utf8_field_tokenizer_unit");
		$finish;
	end

	// result side: check each transfer, then stall on a mask re-rolled whenever the low five bits of rx_tick are zero
	always @(posedge clk) begin
		token_t got;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got.kind = out_ch.result_kind;
			got.index = out_ch.field_index;
			got.start = out_ch.field_start;
			got.length = out_ch.field_length;
			got.count = out_ch.field_count;
			got.status = out_ch.line_status;
			got.last = out_ch.last_result;
			tracker.match_token(got);
		end
		rx_tick = rx_tick + 1;
		if (rx_tick[4:0] == 5'd0)
			rx_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
		out_ch.ready <= rx_mask[rx_tick[2:0]];
	end

	task automatic send_item(input logic [7:0] b, input logic eol, input logic zero);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 24);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.end_of_line <= eol;
		in_ch.zero_length_line <= zero;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		tracker.take_byte(b, eol, zero);
		burst_left--;
		sent_items++;
	endtask

	task automatic send_line();
		for (int i = 0; i < line_bytes.size(); i++)
			send_item(line_bytes[i], i == line_bytes.size() - 1, 1'b0);
	endtask

	task automatic drain(input int limit);
		int n;
		n = 0;
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (tracker.pending() > 0 && n < limit) begin
			@(posedge clk);
			n++;
		end
		// bytes that give no result may still be in flight
		repeat (8) @(posedge clk);
	endtask

	task automatic set_max_fields(input logic [3:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.max_fields = v;
	endtask

	function automatic void put_space();
		int v;
		v = $urandom_range(0, 5);
		line_bytes.push_back((v == 5) ? 8'h20 : 8'(8'h09 + v));
	endfunction

	function automatic void put_tails(input int n);
		repeat (n) line_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
	endfunction

	function automatic void put_noise(input int n);
		repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	// one well-formed character, boundary leads included
	function automatic void put_char();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				do b = 8'($urandom_range(1, 127));
				while (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D));
				line_bytes.push_back(b);
			end
			4: begin
				line_bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
				put_tails(1);
			end
			5: begin
				line_bytes.push_back(LEAD3_LO);
				line_bytes.push_back(8'($urandom_range(RAISE3_LO, TAIL_HI)));
				put_tails(1);
			end
			6: begin
				b = 8'($urandom_range(8'hE1, LEAD3_HI));
				line_bytes.push_back((b == LEAD3_CUT) ? 8'hEE : b);
				put_tails(2);
			end
			7: begin
				line_bytes.push_back(LEAD3_CUT);
				line_bytes.push_back(8'($urandom_range(TAIL_LO, CUT3_HI)));
				put_tails(1);
			end
			8: begin
				line_bytes.push_back(LEAD4_LO);
				line_bytes.push_back(8'($urandom_range(RAISE4_LO, TAIL_HI)));
				put_tails(2);
			end
			default: begin
				if ($urandom_range(0, 1) == 0) begin
					line_bytes.push_back(8'($urandom_range(8'hF1, 8'hF3)));
					put_tails(3);
				end else begin
					line_bytes.push_back(LEAD4_HI);
					line_bytes.push_back(8'($urandom_range(TAIL_LO, CUT4_HI)));
					put_tails(2);
				end
			end
		endcase
	endfunction

	// one malformed sequence: bad lead, out-of-range tail, or cut short
	function automatic void put_bad();
		case ($urandom_range(0, 6))
			0: line_bytes.push_back(8'($urandom_range(TAIL_LO, 8'hC1)));
			1: line_bytes.push_back(8'($urandom_range(8'hF5, 8'hFF)));
			2: begin
				line_bytes.push_back(LEAD3_LO);
				line_bytes.push_back(8'($urandom_range(TAIL_LO, 8'h9F)));
			end
			3: begin
				line_bytes.push_back(LEAD3_CUT);
				line_bytes.push_back(8'($urandom_range(8'hA0, TAIL_HI)));
			end
			4: begin
				if ($urandom_range(0, 1) == 0) begin
					line_bytes.push_back(LEAD4_LO);
					line_bytes.push_back(8'($urandom_range(TAIL_LO, 8'h8F)));
				end else begin
					line_bytes.push_back(LEAD4_HI);
					line_bytes.push_back(8'($urandom_range(8'h90, TAIL_HI)));
				end
			end
			5: line_bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
			default: begin
				line_bytes.push_back(8'($urandom_range(8'hE1, 8'hEC)));
				put_tails(1);
				line_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
					: 8'($urandom_range(8'hC0, 8'hFF)));
			end
		endcase
	endfunction

	function automatic void build_line();
		int kind;
		int nf;
		int nc;
		int bad_f;
		int bad_c;
		line_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 72) begin
			nf = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 17) : $urandom_range(1, 5);
			bad_f = (kind < 60) ? -1 : $urandom_range(0, nf - 1);
			repeat ($urandom_range(0, 2)) put_space();
			for (int f = 0; f < nf; f++) begin
				if (f > 0) repeat ($urandom_range(1, 3)) put_space();
				nc = $urandom_range(1, 5);
				bad_c = $urandom_range(0, nc - 1);
				for (int c = 0; c < nc; c++) begin
					if (f == bad_f && c == bad_c) put_bad();
					else put_char();
				end
			end
			repeat ($urandom_range(0, 2)) put_space();
			if ($urandom_range(0, 7) == 0) begin
				line_bytes.push_back(CH_NUL);
				put_noise($urandom_range(0, 3));
			end
		end else if (kind < 80) begin
			repeat ($urandom_range(0, 2)) put_space();
			line_bytes.push_back(CH_HASH);
			put_noise($urandom_range(0, 6));
		end else if (kind < 88) begin
			repeat ($urandom_range(0, 3)) put_space();
			if ($urandom_range(0, 2) == 0) begin
				line_bytes.push_back(CH_NUL);
				put_noise($urandom_range(0, 3));
			end
			if (line_bytes.size() == 0) put_space();
		end else begin
			put_noise($urandom_range(1, 12));
		end
	endfunction

	initial begin
		logic [3:0] limits[9];
		int first;
		int cut;
		tracker = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 4'd0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= 8'h00;
		in_ch.end_of_line <= 1'b0;
		in_ch.zero_length_line <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines at the reset value of max_fields
		send_item(8'hFF, 1'b1, 1'b1);
		line_bytes = {8'h61, 8'h09, 8'hC2, 8'h80, 8'h20, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_line();
		line_bytes = {CH_HASH};
		send_line();
		line_bytes = {CH_NUL};
		send_line();
		line_bytes = {8'h20, 8'hE0, 8'h9F};
		send_line();
		line_bytes = {8'hFF};
		send_line();
		line_bytes = {8'hE0, 8'hA0};
		send_line();
		line_bytes = {8'h7F, CH_NUL, 8'h41};
		send_line();
		send_item(8'h78, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		drain(2000);

		limits = '{4'd15, 4'd0, 4'd1, 4'd4, 4'd15, 4'd2, 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15)), 4'd3};
		foreach (limits[k]) begin
			set_max_fields(limits[k]);
			first = sent_items;
			while (sent_items - first < 150) begin
				if ($urandom_range(0, 99) < 3) begin
					send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
				end else begin
					build_line();
					if ($urandom_range(0, 99) < 4) begin
						// line dropped by an empty-line transfer in mid-stream
						cut = $urandom_range(0, line_bytes.size() - 1);
						for (int i = 0; i < cut; i++) send_item(line_bytes[i], 1'b0, 1'b0);
						send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
					end else begin
						send_line();
					end
				end
			end
			drain(2000);
		end

		if (tracker.pending() > 0) begin
			$error("%0d expected results never arrived", tracker.pending());
			tracker.mismatches++;
		end
		if (tracker.mismatches == 0)
			$display("PASS utf8_field_tokenizer_unit");
		else
			$display("FAIL utf8_field_tokenizer_unit");
		$finish;
	end

endmodule
